/* sv/tlbr_pkg.sv */
package tlbr_pkg;

	// Table geometry and field widths.
	localparam int ENTRIES    = 16;
	localparam int PID_W      = 16;
	localparam int PAGE_W     = 20;
	localparam int FRAME_W    = 20;
	localparam int STAMP_W    = 64;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int ENT_CFG_W  = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = CFG_IDX_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_SHIFT = 3'b100
	} state_t;

	// One translation entry as held by a cell.
	typedef struct packed {
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Per-cell controls from the sequencer.
	typedef struct packed {
		logic wr;
		logic touch;
		logic shift;
	} cell_ctrl_t;

endpackage

/* sv/tlbr_req_if.sv */
interface tlbr_req_if import tlbr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [PID_W-1:0]   proc_id;
	logic [PAGE_W-1:0]  page_num;
	logic [FRAME_W-1:0] frame_in;

	modport source (output valid, opcode, proc_id, page_num, frame_in, input ready);
	modport sink (input valid, opcode, proc_id, page_num, frame_in, output ready);
endinterface

/* sv/tlbr_rsp_if.sv */
interface tlbr_rsp_if import tlbr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FRAME_W-1:0] frame_out;

	modport source (output valid, hit, frame_out, input ready);
	modport sink (input valid, hit, frame_out, output ready);
endinterface

/* sv/tlbr_cfg_if.sv */
interface tlbr_cfg_if import tlbr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/tlb_fifo_lru_replacement_unit.sv */
// Fully associative TLB tagged by process id and page number, built as a row
// of entry cells with a small sequencer.
// The req channel carries one operation per beat: lookup, insert, clear by
// process id or flush. Every accepted beat yields exactly one rsp beat (hit
// and frame for a lookup, zeros otherwise), registered and offered in the cycle after the
// request is accepted. The cfg channel writes lru_mode (index 0) and
// entries_in_use (index 1); it is always ready and must only be used idle.
// Lookups, appending inserts, FIFO replacements and flushes stay in the idle
// state, so they stream at one per cycle while rsp is taken. An LRU
// replacement walks the stored stamps one cell per cycle and holds off the
// next request until the scan is done. A clear removes one matching entry
// per cycle by shifting the cells above it down, so it holds off the next
// request until every matching entry is removed.
// Reset empties the table, zeroes the use clock and FIFO pointer, selects LRU
// mode and 16 entries in use. While rsp is stalled the result is held and a
// new request is accepted only in the cycle in which rsp is taken.
module tlb_fifo_lru_replacement_unit import tlbr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tlbr_req_if.sink   req,
	tlbr_rsp_if.source rsp,
	tlbr_cfg_if.sink   cfg
);

	state_t               state_q;
	logic [CNT_W-1:0]     fill_q;
	logic [IDX_W-1:0]     fifo_q;
	logic [STAMP_W-1:0]   clock_q;
	logic                 lru_q;
	logic [ENT_CFG_W-1:0] ent_cfg_q;
	logic [ENTRIES-1:0]   mark_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic [IDX_W-1:0]     victim_q;
	logic [STAMP_W-1:0]   min_q;
	entry_t               hold_q;
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   frame_q;

	entry_t               ents [ENTRIES];
	entry_t               up_ents [ENTRIES];
	cell_ctrl_t           ctrls [ENTRIES];
	logic [ENTRIES-1:0]   tag_hits;
	logic [ENTRIES-1:0]   pid_hits;

	op_t                  op;
	logic                 accept;
	logic [CNT_W-1:0]     lim;
	logic                 append;
	logic [IDX_W-1:0]     fifo_p;
	logic [CNT_W-1:0]     fifo_nx;
	logic [ENTRIES-1:0]   valid_vec;
	logic [ENTRIES-1:0]   tag_vec;
	logic [ENTRIES-1:0]   first_vec;
	logic                 hit_any;
	logic [FRAME_W-1:0]   frame_sel;
	logic [ENTRIES-1:0]   mark_low;
	logic [ENTRIES-1:0]   mark_clr;
	logic [ENTRIES-1:0]   shift_vec;
	logic [ENTRIES-1:0]   mark_next;
	logic [STAMP_W-1:0]   stamp_nx;
	logic [STAMP_W-1:0]   cand;
	logic                 wr_en;
	logic [IDX_W-1:0]     widx;
	entry_t               wr_ent;

	assign op       = op_t'(req.opcode);
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign stamp_nx = clock_q + STAMP_W'(1);

	// Row of entry cells; the top cell feeds itself during compaction.
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		if (k == ENTRIES - 1) begin : g_top
			assign up_ents[k] = ents[k];
		end else begin : g_mid
			assign up_ents[k] = ents[k + 1];
		end

		assign ctrls[k].wr    = wr_en && (widx == IDX_W'(k));
		assign ctrls[k].touch = accept && (op == OP_LOOKUP) && first_vec[k];
		assign ctrls[k].shift = (state_q == ST_SHIFT) && shift_vec[k];

		tlbr_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrls[k]),
			.wr_ent  (wr_ent),
			.up_ent  (up_ents[k]),
			.q_pid   (req.proc_id),
			.q_page  (req.page_num),
			.ent     (ents[k]),
			.tag_hit (tag_hits[k]),
			.pid_hit (pid_hits[k])
		);
	end

	// Effective entry limit: zero acts as one, anything past the table as full.
	always_comb begin
		if (ent_cfg_q == '0) begin
			lim = CNT_W'(1);
		end else if (32'(ent_cfg_q) > ENTRIES) begin
			lim = CNT_W'(ENTRIES);
		end else begin
			lim = CNT_W'(ent_cfg_q);
		end
	end

	// Match selection: the lowest valid matching cell wins.
	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			valid_vec[k] = (CNT_W'(k) < fill_q);
		end
		tag_vec   = tag_hits & valid_vec;
		first_vec = tag_vec & (~tag_vec + ENTRIES'(1));
		hit_any   = |tag_vec;
		frame_sel = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			frame_sel = frame_sel | (first_vec[k] ? ents[k].frame : '0);
		end
	end

	// Compaction step: every cell at or above the lowest marked one shifts down.
	always_comb begin
		mark_low  = mark_q & (~mark_q + ENTRIES'(1));
		shift_vec = ~(mark_low - ENTRIES'(1));
		mark_clr  = mark_q & ~mark_low;
		mark_next = (mark_clr & ~shift_vec) | ((mark_clr >> 1) & shift_vec);
	end

	// Insert target selection.
	always_comb begin
		append = (fill_q < lim);
		fifo_p = (CNT_W'(fifo_q) >= lim) ? '0 : fifo_q;
		fifo_nx = CNT_W'(fifo_p) + CNT_W'(1);
		if (fifo_nx >= lim) begin
			fifo_nx = '0;
		end
		cand = ents[scan_idx_q[IDX_W-1:0]].stamp;

		wr_en = 1'b0;
		widx  = '0;
		if (state_q == ST_SCAN) begin
			wr_en = (scan_idx_q == fill_q);
			widx  = victim_q;
		end else if (accept && (op == OP_INSERT) && (append || !lru_q)) begin
			wr_en = 1'b1;
			widx  = append ? fill_q[IDX_W-1:0] : fifo_p;
		end

		if (state_q == ST_SCAN) begin
			wr_ent = hold_q;
		end else begin
			wr_ent.pid   = req.proc_id;
			wr_ent.page  = req.page_num;
			wr_ent.frame = req.frame_in;
		end
		wr_ent.stamp = stamp_nx;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lru_q     <= 1'b1;
			ent_cfg_q <= ENT_CFG_W'(16);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_LRU_MODE:       lru_q     <= cfg.data[0];
				CFG_ENTRIES_IN_USE: ent_cfg_q <= ENT_CFG_W'(cfg.data);
				default:            ;
			endcase
		end
	end

	// Sequencer and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			fifo_q      <= '0;
			clock_q     <= '0;
			mark_q      <= '0;
			scan_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_LOOKUP: begin
								if (hit_any) begin
									clock_q <= stamp_nx;
								end
							end
							OP_INSERT: begin
								if (append) begin
									clock_q <= stamp_nx;
									fill_q  <= fill_q + CNT_W'(1);
								end else if (lru_q) begin
									scan_idx_q <= CNT_W'(1);
									state_q    <= ST_SCAN;
								end else begin
									clock_q <= stamp_nx;
									fifo_q  <= fifo_nx[IDX_W-1:0];
								end
							end
							OP_CLEAR: begin
								mark_q <= pid_hits & valid_vec;
								if (|(pid_hits & valid_vec)) begin
									state_q <= ST_SHIFT;
								end
							end
							OP_FLUSH: begin
								fill_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == fill_q) begin
						clock_q <= stamp_nx;
						state_q <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					fill_q <= fill_q - CNT_W'(1);
					mark_q <= mark_next;
					if (mark_next == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register and LRU scan datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q   <= (op == OP_LOOKUP) && hit_any;
			frame_q <= ((op == OP_LOOKUP) && hit_any) ? frame_sel : '0;
		end
		if (accept && (op == OP_INSERT)) begin
			hold_q.pid   <= req.proc_id;
			hold_q.page  <= req.page_num;
			hold_q.frame <= req.frame_in;
			hold_q.stamp <= '0;
			min_q        <= ents[0].stamp;
			victim_q     <= '0;
		end else if ((state_q == ST_SCAN) && (scan_idx_q != fill_q) && (cand < min_q)) begin
			min_q    <= cand;
			victim_q <= scan_idx_q[IDX_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = hit_q;
	assign rsp.frame_out = frame_q;

	// The fill count never passes the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond table size");

	// Compaction only runs while an entry is still marked for removal.
	a_shift_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (mark_q != '0))
		else $error("compaction with no marked entry");

	// Each compaction cycle removes exactly one entry.
	a_shift_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |=> (fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("compaction did not drop one entry");

	// The LRU scan index stays between one and the fill count.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((scan_idx_q != '0) && (scan_idx_q <= fill_q)))
		else $error("LRU scan index out of range");

	// A flush leaves the table empty.
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_FLUSH)) |=> (fill_q == '0))
		else $error("flush left entries behind");

endmodule

/* sv/tlbr_cell.sv */
module tlbr_cell import tlbr_pkg::*; (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  entry_t            wr_ent,
	input  entry_t            up_ent,
	input  logic [PID_W-1:0]  q_pid,
	input  logic [PAGE_W-1:0] q_page,
	output entry_t            ent,
	output logic              tag_hit,
	output logic              pid_hit
);

	entry_t ent_q;

	// A write loads a whole entry, a touch refreshes the stamp, and a shift
	// takes the entry of the next cell up during compaction.
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			ent_q <= wr_ent;
		end else if (ctrl.touch) begin
			ent_q.stamp <= wr_ent.stamp;
		end else if (ctrl.shift) begin
			ent_q <= up_ent;
		end
	end

	// Tag compares for lookup and clear by process.
	assign pid_hit = (ent_q.pid == q_pid);
	assign tag_hit = pid_hit && (ent_q.page == q_page);
	assign ent     = ent_q;

endmodule
